FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, clocked on clk, off during rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/lsdrs_pkg.sv
// ----------------------------------------------------------------------------
// lsdrs_pkg
// shared constants and types of the decimal radix sort core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsdrs_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int MAX_DIGITS  = 6;
  localparam int VALUE_W     = 20;
  localparam int PASS_W      = 3;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int RADIX       = 10;
  localparam int DIG_W       = $clog2(RADIX);
  localparam int PASSES_RST  = 3;

  // x / 10 == (x * RECIP) >> RECIP_SHIFT, exact for x below 2**22
  localparam logic [VALUE_W-1:0] RECIP = VALUE_W'(838861);
  localparam int RECIP_SHIFT = 23;
  localparam int PROD_W      = 2 * VALUE_W;

  // queue depth, power of two
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } lsdrs_item_t;

  // store entry: original value plus value / 10**pass
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] quo;
  } lsdrs_ent_t;

endpackage

FILE: rtl/lsdrs_fifo.sv
// ----------------------------------------------------------------------------
// lsdrs_fifo
// short register queue of items, push/full on one side and pop/empty on the other
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsdrs_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsdrs_pkg::lsdrs_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output lsdrs_pkg::lsdrs_item_t head_item,
  output logic                 empty
);
  import lsdrs_pkg::*;

  lsdrs_item_t        ent_r [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full      = (cnt_r == QCNT_W'(Q_DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/lsdrs_front.sv
// ----------------------------------------------------------------------------
// lsdrs_front
// input side: takes beats and marks the one that closes a set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsdrs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic [lsdrs_pkg::VALUE_W-1:0] in_value,
  input  logic                   in_last_in,
  output logic                   in_full,
  output logic                   q_push,
  output lsdrs_pkg::lsdrs_item_t q_item,
  input  logic                   q_full
);
  import lsdrs_pkg::*;

  logic [IDX_W-1:0] set_cnt_r;
  logic             accept;
  logic             store_full;

  assign in_full    = q_full;
  assign accept     = in_push && !q_full;
  // the beat filling the last store entry closes the set on its own
  assign store_full = (set_cnt_r == IDX_W'(MAX_ITEMS - 1));
  assign q_push     = in_push;
  assign q_item     = '{value: in_value, last: in_last_in || store_full};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_cnt_r <= '0;
    end else if (accept) begin
      if (in_last_in || store_full) begin
        set_cnt_r <= '0;
      end else begin
        set_cnt_r <= set_cnt_r + IDX_W'(1);
      end
    end
  end

endmodule

FILE: rtl/lsdrs_back.sv
// ----------------------------------------------------------------------------
// lsdrs_back
// sort engine: loads a set, runs the configured counting-sort passes (if any)
// over ping-pong stores, then streams the sorted set out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsdrs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [lsdrs_pkg::PASS_W-1:0] cfg_data,
  input  lsdrs_pkg::lsdrs_item_t q_item,
  input  logic                   q_empty,
  output logic                   q_pop,
  output lsdrs_pkg::lsdrs_item_t o_item,
  output logic                   o_push,
  input  logic                   o_full
);
  import lsdrs_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLR,
    S_CNT_RD,
    S_CNT_MUL,
    S_CNT_DIG,
    S_PFX,
    S_SCT_RD,
    S_SCT_MUL,
    S_SCT_DIG,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   n_r;
  logic [IDX_W-1:0]   idx_r;
  logic [PASS_W-1:0]  pass_r;
  logic [PASS_W-1:0]  passes_r;
  logic [PASS_W-1:0]  digit_passes_r;
  logic               src_r;
  logic [CNT_W-1:0]   cnt_r [RADIX];

  lsdrs_ent_t         mem0 [MAX_ITEMS];
  lsdrs_ent_t         mem1 [MAX_ITEMS];
  lsdrs_ent_t         rd0_r;
  lsdrs_ent_t         rd1_r;
  lsdrs_ent_t         rd_ent;

  logic [PROD_W-1:0]  prod_r;
  logic [VALUE_W-1:0] q_r;
  logic [VALUE_W-1:0] v_r;

  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] diff;
  logic [DIG_W-1:0]   dig;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pfx [RADIX];
  logic [PASS_W-1:0]  passes_lim;
  logic               idx_last;
  logic               we_load;
  logic               we_sct;
  logic               we0;
  logic               we1;
  logic [IDX_W-1:0]   wr_addr;
  lsdrs_ent_t         wr_ent;

  assign passes_lim = (digit_passes_r > PASS_W'(MAX_DIGITS)) ? PASS_W'(MAX_DIGITS)
                                                              : digit_passes_r;
  assign idx_last   = ({1'b0, idx_r} == (n_r - CNT_W'(1)));

  // digit = q - 10 * (q / 10), next quotient kept for the following pass
  assign quo  = VALUE_W'(prod_r[PROD_W-1:RECIP_SHIFT]);
  assign diff = q_r - ({quo[VALUE_W-4:0], 3'b000} + {quo[VALUE_W-2:0], 1'b0});
  assign dig  = diff[DIG_W-1:0];
  assign pos  = cnt_r[dig] - CNT_W'(1);

  always_comb begin
    pfx[0] = cnt_r[0];
    for (int d = 1; d < RADIX; d++) begin
      pfx[d] = pfx[d-1] + cnt_r[d];
    end
  end

  assign q_pop   = (state_r == S_LOAD) && !q_empty;
  assign we_load = q_pop;
  assign we_sct  = (state_r == S_SCT_DIG);
  assign we0     = (we_load && !src_r) || (we_sct && src_r);
  assign we1     = (we_load && src_r) || (we_sct && !src_r);
  assign wr_addr = we_load ? n_r[IDX_W-1:0] : pos[IDX_W-1:0];
  assign wr_ent  = we_load ? '{value: q_item.value, quo: q_item.value}
                           : '{value: v_r, quo: quo};
  assign rd_ent  = src_r ? rd1_r : rd0_r;

  assign o_push  = (state_r == S_EMIT_WR);
  assign o_item  = '{value: rd_ent.value, last: idx_last};

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= wr_ent;
    end
    rd0_r <= mem0[idx_r];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wr_addr] <= wr_ent;
    end
    rd1_r <= mem1[idx_r];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_CNT_MUL) || (state_r == S_SCT_MUL)) begin
      prod_r <= {{VALUE_W{1'b0}}, rd_ent.quo} * {{VALUE_W{1'b0}}, RECIP};
      q_r    <= rd_ent.quo;
      v_r    <= rd_ent.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_LOAD;
      n_r            <= '0;
      idx_r          <= '0;
      pass_r         <= '0;
      passes_r       <= '0;
      src_r          <= 1'b0;
      digit_passes_r <= PASS_W'(PASSES_RST);
      for (int d = 0; d < RADIX; d++) begin
        cnt_r[d] <= '0;
      end
    end else begin
      if (cfg_we) begin
        digit_passes_r <= cfg_data;
      end
      case (state_r)
        S_LOAD: begin
          if (!q_empty) begin
            n_r <= n_r + CNT_W'(1);
            if (q_item.last) begin
              idx_r    <= '0;
              pass_r   <= '0;
              passes_r <= passes_lim;
              state_r  <= (passes_lim == '0) ? S_EMIT_RD : S_CLR;
            end
          end
        end
        S_CLR: begin
          for (int d = 0; d < RADIX; d++) begin
            cnt_r[d] <= '0;
          end
          idx_r   <= '0;
          state_r <= S_CNT_RD;
        end
        S_CNT_RD:  state_r <= S_CNT_MUL;
        S_CNT_MUL: state_r <= S_CNT_DIG;
        S_CNT_DIG: begin
          cnt_r[dig] <= cnt_r[dig] + CNT_W'(1);
          if (idx_last) begin
            state_r <= S_PFX;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_CNT_RD;
          end
        end
        S_PFX: begin
          for (int d = 0; d < RADIX; d++) begin
            cnt_r[d] <= pfx[d];
          end
          idx_r   <= IDX_W'(n_r - CNT_W'(1));
          state_r <= S_SCT_RD;
        end
        S_SCT_RD:  state_r <= S_SCT_MUL;
        S_SCT_MUL: state_r <= S_SCT_DIG;
        S_SCT_DIG: begin
          // walk backward so equal digits keep arrival order
          cnt_r[dig] <= pos;
          if (idx_r == '0) begin
            src_r  <= ~src_r;
            pass_r <= pass_r + PASS_W'(1);
            if ((pass_r + PASS_W'(1)) == passes_r) begin
              state_r <= S_EMIT_RD;
            end else begin
              state_r <= S_CLR;
            end
          end else begin
            idx_r   <= idx_r - IDX_W'(1);
            state_r <= S_SCT_RD;
          end
        end
        S_EMIT_RD: begin
          if (!o_full) begin
            state_r <= S_EMIT_WR;
          end
        end
        S_EMIT_WR: begin
          if (idx_last) begin
            n_r     <= '0;
            idx_r   <= '0;
            state_r <= S_LOAD;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_EMIT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: rtl/lsd_decimal_radix_sort_core.sv
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sort_core
// LSD base-10 radix sort of up to 64 values per set, sorted beats out in order
// ----------------------------------------------------------------------------
// channel   ports                                  beat taken when
// input     in_push in_full in_value in_last_in    in_push && !in_full
// result    out_pop out_empty out_sorted_value ... out_pop && !out_empty
// config    cfg_we cfg_data                        cfg_we
//
// loading runs one beat per cycle while in_full is low, into a 4-entry queue;
// the engine pops it while loading a set; each digit pass clears the buckets,
// then counts and scatters with a store read, reciprocal multiply and bucket
// update per value; results are read, then pushed to a 4-entry output queue
// reset is synchronous on rst_n; the stores need no clearing pass
// a stalled result side holds the engine, inputs queue up behind it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsd_decimal_radix_sort_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [lsdrs_pkg::VALUE_W-1:0]  in_value,
  input  logic                           in_last_in,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [lsdrs_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic                           out_last_out,
  input  logic                           cfg_we,
  input  logic [lsdrs_pkg::PASS_W-1:0]   cfg_data
);
  import lsdrs_pkg::*;

  `include "assert_macros.svh"

  logic        fq_push;
  lsdrs_item_t fq_in;
  logic        fq_full;
  lsdrs_item_t fq_head;
  logic        fq_empty;
  logic        fq_pop;

  lsdrs_item_t oq_in;
  logic        oq_push;
  logic        oq_full;
  lsdrs_item_t oq_head;

  lsdrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_value   (in_value),
    .in_last_in (in_last_in),
    .in_full    (in_full),
    .q_push     (fq_push),
    .q_item     (fq_in),
    .q_full     (fq_full)
  );

  lsdrs_fifo u_in_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_in),
    .full      (fq_full),
    .pop       (fq_pop),
    .head_item (fq_head),
    .empty     (fq_empty)
  );

  lsdrs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_item   (fq_head),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .o_item   (oq_in),
    .o_push   (oq_push),
    .o_full   (oq_full)
  );

  lsdrs_fifo u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_item (oq_in),
    .full      (oq_full),
    .pop       (out_pop),
    .head_item (oq_head),
    .empty     (out_empty)
  );

  assign out_sorted_value = oq_head.value;
  assign out_last_out     = oq_head.last;

  // engine must never drop a sorted beat into a full output queue
  `ASSERT_NEVER(a_no_push_full_out, oq_push && oq_full, "result pushed into full queue")
  // engine must only take from the input queue when it holds a beat
  `ASSERT_NEVER(a_no_pop_empty_in, fq_pop && fq_empty, "input queue popped while empty")
  // while results are being emitted, no new set is loaded
  `ASSERT_ALWAYS(a_emit_excl_load, oq_push |-> !fq_pop, "load overlapped result emission")

endmodule
